// ===== rtl/sld_crc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_crc_pkg
// Shared types, constants and the byte-wise CRC-16-CCITT update for the
// sync/length packet deframer.
// ----------------------------------------------------------------------------
package sld_crc_pkg;

    localparam int MAX_PAYLOAD = 256;

    localparam logic [7:0]  FRAME_SYNC  = 8'hAA;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [16:0] FRAME_LIMIT = 17'(MAX_PAYLOAD + 6);
    localparam logic [16:0] FRAME_OVERHEAD = 17'd6;
    localparam logic [16:0] HEADER_BYTES   = 17'd4;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        EVT_PAYLOAD  = 2'd0,
        EVT_GOOD     = 2'd1,
        EVT_CRC_ERR  = 2'd2,
        EVT_OVERFLOW = 2'd3
    } evt_kind_t;

    typedef struct packed {
        logic       valid;
        logic       req_type;
        logic [7:0] rx_byte;
    } req_beat_t;

    typedef struct packed {
        evt_kind_t   event_kind;
        logic [7:0]  packet_kind;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic [15:0] received_check;
        logic [15:0] computed_check;
        logic [31:0] good_total;
        logic [31:0] error_total;
    } evt_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sld_crc_byte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_crc_byte_if
// Request channel: received bytes and counter-clear requests.
// ----------------------------------------------------------------------------
interface sld_crc_byte_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/sld_crc_event_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_crc_event_if
// Event channel: payload bytes and end-of-packet reports with counters.
// ----------------------------------------------------------------------------
interface sld_crc_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  packet_kind;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
    logic [15:0] received_check;
    logic [15:0] computed_check;
    logic [31:0] good_total;
    logic [31:0] error_total;

    modport source (output valid, output event_kind, output packet_kind,
                    output frame_length, output data_byte, output received_check,
                    output computed_check, output good_total, output error_total,
                    input ready);
    modport sink   (input valid, input event_kind, input packet_kind,
                    input frame_length, input data_byte, input received_check,
                    input computed_check, input good_total, input error_total,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/sld_crc_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_crc_in_stage
// Input register: captures one request beat, holds it while the framing
// stage is stalled.
// ----------------------------------------------------------------------------
module sld_crc_in_stage (
    input  wire                       clk,
    input  wire                       rst_n,
    sld_crc_byte_if.sink              byte_chan,
    input  wire                       take,
    output sld_crc_pkg::req_beat_t    beat
);

    logic       valid_reg;
    logic       valid_next;
    logic       req_type_reg;
    logic [7:0] rx_byte_reg;
    logic       load;

    assign byte_chan.ready = !valid_reg || take;
    assign load            = byte_chan.valid && byte_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_chan.ready)
        begin
            valid_next = byte_chan.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_type_reg <= byte_chan.req_type;
            rx_byte_reg  <= byte_chan.rx_byte;
        end
    end

    assign beat.valid    = valid_reg;
    assign beat.req_type = req_type_reg;
    assign beat.rx_byte  = rx_byte_reg;

endmodule
`default_nettype wire

// ===== rtl/sld_crc_deframe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_crc_deframe
// Framing state, CRC update, counters and the registered event output.
// One request beat is consumed per cycle whenever the output slot is free.
// ----------------------------------------------------------------------------
module sld_crc_deframe (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire sld_crc_pkg::req_beat_t beat,
    output logic                      take,
    sld_crc_event_if.source           event_chan
);

    logic        in_packet_reg,  in_packet_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  kind_reg,       kind_next;
    logic [15:0] length_reg,     length_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  chk_hi_reg,     chk_hi_next;
    logic [31:0] good_reg,       good_next;
    logic [31:0] error_reg,      error_next;

    logic                    evt_valid_reg, evt_valid_next;
    sld_crc_pkg::evt_t       evt_reg;
    sld_crc_pkg::evt_t       evt_next;

    logic                    fire;
    logic                    emit;
    sld_crc_pkg::evt_kind_t  emit_kind;
    logic [7:0]              emit_data;
    logic [15:0]             emit_rcv;
    logic [15:0]             crc_upd;
    logic [16:0]             idx_p1;
    logic                    end_hit;
    logic                    in_payload;
    logic                    overflow;
    logic [15:0]             rcv_check;

    assign take    = !evt_valid_reg || event_chan.ready;
    assign fire    = beat.valid && take;

    assign crc_upd    = sld_crc_pkg::crc_byte(crc_reg, beat.rx_byte);
    assign idx_p1     = {1'b0, byte_count_reg} + 17'd1;
    assign end_hit    = idx_p1 >= ({1'b0, length_reg} + sld_crc_pkg::FRAME_OVERHEAD);
    assign in_payload = {1'b0, byte_count_reg} < ({1'b0, length_reg} + sld_crc_pkg::HEADER_BYTES);
    assign overflow   = idx_p1 >= sld_crc_pkg::FRAME_LIMIT;
    assign rcv_check  = {chk_hi_reg, beat.rx_byte};

    // framing next state
    always_comb
    begin
        in_packet_next  = in_packet_reg;
        byte_count_next = byte_count_reg;
        kind_next       = kind_reg;
        length_next     = length_reg;
        crc_next        = crc_reg;
        chk_hi_next     = chk_hi_reg;
        good_next       = good_reg;
        error_next      = error_reg;
        emit            = 1'b0;
        emit_kind       = sld_crc_pkg::EVT_PAYLOAD;
        emit_data       = 8'h00;
        emit_rcv        = 16'h0000;

        if (fire)
        begin
            if (beat.req_type == sld_crc_pkg::REQ_CLEAR)
            begin
                good_next  = 32'd0;
                error_next = 32'd0;
            end
            else if (!in_packet_reg)
            begin
                if (beat.rx_byte == sld_crc_pkg::FRAME_SYNC)
                begin
                    in_packet_next  = 1'b1;
                    byte_count_next = 16'd1;
                    crc_next        = sld_crc_pkg::crc_byte(sld_crc_pkg::CRC_INIT,
                                                            beat.rx_byte);
                end
            end
            else
            begin
                byte_count_next = idx_p1[15:0];
                if (byte_count_reg[15:2] == 14'd0)
                begin
                    // header: type, then length high and low
                    if (byte_count_reg[1:0] == 2'd1)
                    begin
                        kind_next = beat.rx_byte;
                    end
                    else
                    begin
                        length_next = {length_reg[7:0], beat.rx_byte};
                    end
                    crc_next = crc_upd;
                end
                else if (end_hit)
                begin
                    in_packet_next  = 1'b0;
                    byte_count_next = 16'd0;
                    emit            = 1'b1;
                    emit_rcv        = rcv_check;
                    if (rcv_check == crc_reg)
                    begin
                        good_next = good_reg + 32'd1;
                        emit_kind = sld_crc_pkg::EVT_GOOD;
                    end
                    else
                    begin
                        error_next = error_reg + 32'd1;
                        emit_kind  = sld_crc_pkg::EVT_CRC_ERR;
                    end
                end
                else
                begin
                    if (in_payload)
                    begin
                        crc_next = crc_upd;
                    end
                    else
                    begin
                        chk_hi_next = beat.rx_byte;
                    end
                    if (overflow)
                    begin
                        in_packet_next  = 1'b0;
                        byte_count_next = 16'd0;
                        error_next      = error_reg + 32'd1;
                        emit            = 1'b1;
                        emit_kind       = sld_crc_pkg::EVT_OVERFLOW;
                    end
                    else if (in_payload)
                    begin
                        emit      = 1'b1;
                        emit_kind = sld_crc_pkg::EVT_PAYLOAD;
                        emit_data = beat.rx_byte;
                    end
                end
            end
        end
    end

    // event output register
    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (take)
        begin
            evt_valid_next = fire && emit;
        end
        evt_next.event_kind     = emit_kind;
        evt_next.packet_kind    = kind_next;
        evt_next.frame_length   = length_next;
        evt_next.data_byte      = emit_data;
        evt_next.received_check = emit_rcv;
        evt_next.computed_check = crc_next;
        evt_next.good_total     = good_next;
        evt_next.error_total    = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            byte_count_reg <= 16'd0;
            kind_reg       <= 8'd0;
            length_reg     <= 16'd0;
            crc_reg        <= sld_crc_pkg::CRC_INIT;
            chk_hi_reg     <= 8'd0;
            good_reg       <= 32'd0;
            error_reg      <= 32'd0;
            evt_valid_reg  <= 1'b0;
        end
        else
        begin
            in_packet_reg  <= in_packet_next;
            byte_count_reg <= byte_count_next;
            kind_reg       <= kind_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            chk_hi_reg     <= chk_hi_next;
            good_reg       <= good_next;
            error_reg      <= error_next;
            evt_valid_reg  <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            evt_reg <= evt_next;
        end
    end

    assign event_chan.valid          = evt_valid_reg;
    assign event_chan.event_kind     = evt_reg.event_kind;
    assign event_chan.packet_kind    = evt_reg.packet_kind;
    assign event_chan.frame_length   = evt_reg.frame_length;
    assign event_chan.data_byte      = evt_reg.data_byte;
    assign event_chan.received_check = evt_reg.received_check;
    assign event_chan.computed_check = evt_reg.computed_check;
    assign event_chan.good_total     = evt_reg.good_total;
    assign event_chan.error_total    = evt_reg.error_total;

`ifndef SYNTHESIS
    a_hunt_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_packet_reg |-> byte_count_reg == 16'd0)
        else $error("byte count nonzero while hunting");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg |-> (byte_count_reg != 16'd0)
                          && ({1'b0, byte_count_reg} < sld_crc_pkg::FRAME_LIMIT))
        else $error("byte count outside frame window");

    a_good_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && emit_kind == sld_crc_pkg::EVT_GOOD)
        |=> good_reg == $past(good_reg + 32'd1))
        else $error("good event without counter step");

    a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && emit && emit_kind != sld_crc_pkg::EVT_PAYLOAD) |=> !in_packet_reg)
        else $error("framing not released after packet end");
`endif

endmodule
`default_nettype wire

// ===== rtl/sync_length_packet_deframer_crc16_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_packet_deframer_crc16_core
// Receive-side deframer for sync/type/length/payload/CRC-16 byte packets.
// ----------------------------------------------------------------------------
// Usage:
//   byte_chan carries one request per beat: req_type 0 delivers rx_byte,
//   req_type 1 clears the good and error counters.
//   event_chan carries one event per payload byte and one per packet end
//   (good, CRC mismatch or overflow drop), with the header fields, the
//   carried and computed CRC and both counters after the beat.
//   Throughput: one request beat per cycle while the event slot is free or
//   event_chan is ready, set by the combinational CRC byte update in the
//   framing stage. Path: a request beat passes the input register, then
//   the framing stage into the event register.
//   Stall: while event_chan is held, one event and one request wait in
//   their registers; byte_chan.ready then drops.
//   Reset: hunting for sync, CRC at 0xFFFF, counters and header cleared,
//   no event pending.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer_crc16_core (
    input  wire                 clk,
    input  wire                 rst_n,
    sld_crc_byte_if.sink        byte_chan,
    sld_crc_event_if.source     event_chan
);

    sld_crc_pkg::req_beat_t beat;
    logic                   take;

    sld_crc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .take      (take),
        .beat      (beat)
    );

    sld_crc_deframe u_deframe (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .take       (take),
        .event_chan (event_chan)
    );

endmodule
`default_nettype wire

// ===== verif/tb_sync_length_packet_deframer_crc16_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_packet_deframer_crc16_core
// Feeds sync/type/length/payload/CRC byte streams, stray bytes and counter
// clears into the deframer. A cycle-free model of the framing logic predicts
// every payload and end-of-packet event at the beat it is accepted. The event
// monitor checks each event field by field in order, with random stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb_sync_length_packet_deframer_crc16_core;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } byte_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sld_crc_byte_if  byte_chan();
    sld_crc_event_if event_chan();

    sync_length_packet_deframer_crc16_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .event_chan (event_chan)
    );

    always #2 clk = ~clk;

    byte_req_t         pending_reqs[$];
    sld_crc_pkg::evt_t expected_events[$];
    int                stim_count = 0;
    int                mismatches = 0;
    bit                calm = 1'b0;

    // deframer state
    bit          framing   = 1'b0;
    int          frame_pos = 0;
    logic [7:0]  hdr_kind  = '0;
    logic [15:0] hdr_len   = '0;
    logic [15:0] crc_acc   = sld_crc_pkg::CRC_INIT;
    logic [7:0]  crc_hi    = '0;
    logic [31:0] good_cnt  = '0;
    logic [31:0] err_cnt   = '0;

    // MSB-first bit-serial CRC-16-CCITT
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc;
        for (int i = 7; i >= 0; i--)
            c = {c[14:0], 1'b0} ^ ((c[15] ^ b[i]) ? sld_crc_pkg::CRC_POLY : 16'h0000);
        return c;
    endfunction

    task automatic advance_deframer(input logic req, input logic [7:0] b);
        int                pos;
        int                frame_end;
        bit                fire;
        sld_crc_pkg::evt_t ev;
        fire = 1'b0;
        ev   = '0;
        if (req == sld_crc_pkg::REQ_CLEAR)
        begin
            good_cnt = '0;
            err_cnt  = '0;
        end
        else if (!framing)
        begin
            if (b == sld_crc_pkg::FRAME_SYNC)
            begin
                framing   = 1'b1;
                frame_pos = 1;
                crc_acc   = crc16_step(sld_crc_pkg::CRC_INIT, b);
            end
        end
        else
        begin
            pos       = frame_pos;
            frame_pos = frame_pos + 1;
            frame_end = int'(hdr_len) + 6;
            if (pos < 4)
            begin
                if (pos == 1)
                    hdr_kind = b;
                else
                    hdr_len = {hdr_len[7:0], b};
                crc_acc = crc16_step(crc_acc, b);
            end
            else if (pos + 1 >= frame_end)
            begin
                framing           = 1'b0;
                frame_pos         = 0;
                fire              = 1'b1;
                ev.received_check = {crc_hi, b};
                if ({crc_hi, b} == crc_acc)
                begin
                    good_cnt      = good_cnt + 1;
                    ev.event_kind = sld_crc_pkg::EVT_GOOD;
                end
                else
                begin
                    err_cnt       = err_cnt + 1;
                    ev.event_kind = sld_crc_pkg::EVT_CRC_ERR;
                end
            end
            else
            begin
                if (pos < 4 + int'(hdr_len))
                    crc_acc = crc16_step(crc_acc, b);
                else
                    crc_hi = b;
                // overflow is checked after completion
                if (pos + 1 >= sld_crc_pkg::MAX_PAYLOAD + 6)
                begin
                    framing       = 1'b0;
                    frame_pos     = 0;
                    err_cnt       = err_cnt + 1;
                    fire          = 1'b1;
                    ev.event_kind = sld_crc_pkg::EVT_OVERFLOW;
                end
                else if (pos < 4 + int'(hdr_len))
                begin
                    fire          = 1'b1;
                    ev.event_kind = sld_crc_pkg::EVT_PAYLOAD;
                    ev.data_byte  = b;
                end
            end
        end
        if (fire)
        begin
            ev.packet_kind    = hdr_kind;
            ev.frame_length   = hdr_len;
            ev.computed_check = crc_acc;
            ev.good_total     = good_cnt;
            ev.error_total    = err_cnt;
            expected_events.push_back(ev);
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < 30)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic push_item(input logic req, input logic [7:0] b, input bit counted);
        pending_reqs.push_back('{req_type: req, rx_byte: b});
        if (counted)
            stim_count++;
    endtask

    // fill < 0 gives random payload; oversize lengths send bytes up to the limit only
    task automatic queue_packet(input logic [7:0] kind, input logic [15:0] len,
                                input bit spoil, input int fill, input bit trunc,
                                input bit stray_clear);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        int          n;
        int          clear_at;
        frame = {sld_crc_pkg::FRAME_SYNC, kind, len[15:8], len[7:0]};
        n = (int'(len) > sld_crc_pkg::MAX_PAYLOAD) ? sld_crc_pkg::MAX_PAYLOAD + 2
                                                   : int'(len);
        for (int i = 0; i < n; i++)
            frame.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        if (int'(len) <= sld_crc_pkg::MAX_PAYLOAD)
        begin
            crc = sld_crc_pkg::CRC_INIT;
            foreach (frame[i])
                crc = crc16_step(crc, frame[i]);
            if (spoil)
                crc = crc ^ (16'h0001 << $urandom_range(15));
            frame.push_back(crc[15:8]);
            frame.push_back(crc[7:0]);
        end
        if (trunc)
            frame = frame[0:$urandom_range(frame.size() - 2)];
        clear_at = stray_clear ? int'($urandom_range(frame.size() - 1)) : -1;
        foreach (frame[i])
        begin
            if (i == clear_at)
                push_item(sld_crc_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'b1);
            push_item(sld_crc_pkg::REQ_BYTE, frame[i], 1'b1);
        end
    endtask

    task automatic random_traffic(input int target);
        int          r;
        int          n;
        logic [15:0] len;
        logic [7:0]  b;
        while (stim_count < target)
        begin
            r = $urandom_range(99);
            n = $urandom_range(99);
            if (n < 88)
                len = 16'($urandom_range(16));
            else if (n < 96)
                len = 16'($urandom_range(48, 17));
            else if (n < 99)
                len = 16'($urandom_range(sld_crc_pkg::MAX_PAYLOAD,
                                         sld_crc_pkg::MAX_PAYLOAD - 6));
            else
                len = $urandom_range(1) ? 16'hFFFF
                    : 16'($urandom_range(65535, sld_crc_pkg::MAX_PAYLOAD + 1));
            if (r < 70)
                queue_packet(8'($urandom_range(255)), len, $urandom_range(99) < 15, -1,
                             1'b0, $urandom_range(19) == 0);
            else if (r < 82)
            begin
                // idle line noise, never a sync byte
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++)
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == sld_crc_pkg::FRAME_SYNC);
                    push_item(sld_crc_pkg::REQ_BYTE, b, 1'b0);
                end
            end
            else if (r < 90)
                queue_packet(8'($urandom_range(255)), len, 1'b0, -1, 1'b1, 1'b0);
            else if (r < 95)
                push_item(sld_crc_pkg::REQ_CLEAR, 8'($urandom_range(255)), 1'b1);
            else
            begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++)
                    push_item(sld_crc_pkg::REQ_BYTE, 8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || byte_chan.valid || expected_events.size() != 0);
    endtask

    // request driver
    always @(posedge clk)
    begin
        byte_req_t nxt;
        if (rst_n)
        begin
            if (byte_chan.valid && byte_chan.ready)
                advance_deframer(byte_chan.req_type, byte_chan.rx_byte);
            if (!byte_chan.valid || byte_chan.ready)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    nxt = pending_reqs.pop_front();
                    byte_chan.valid    <= 1'b1;
                    byte_chan.req_type <= nxt.req_type;
                    byte_chan.rx_byte  <= nxt.rx_byte;
                end
                else
                    byte_chan.valid <= 1'b0;
            end
        end
        else
        begin
            byte_chan.valid    <= 1'b0;
            byte_chan.req_type <= sld_crc_pkg::REQ_BYTE;
            byte_chan.rx_byte  <= '0;
        end
    end

    // event monitor
    always @(posedge clk)
    begin
        sld_crc_pkg::evt_t want;
        if (rst_n)
        begin
            if (event_chan.valid && event_chan.ready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected event kind %0d",
                                              event_chan.event_kind));
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", event_chan.event_kind, want.event_kind);
                    check_field("packet_kind", event_chan.packet_kind, want.packet_kind);
                    check_field("frame_length", event_chan.frame_length,
                                want.frame_length);
                    check_field("data_byte", event_chan.data_byte, want.data_byte);
                    check_field("received_check", event_chan.received_check,
                                want.received_check);
                    check_field("computed_check", event_chan.computed_check,
                                want.computed_check);
                    check_field("good_total", event_chan.good_total, want.good_total);
                    check_field("error_total", event_chan.error_total, want.error_total);
                end
            end
            event_chan.ready <= calm || ($urandom_range(99) >= 20);
        end
        else
            event_chan.ready <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes, clears while hunting, short packets
        push_item(sld_crc_pkg::REQ_BYTE, 8'h00, 1'b0);
        push_item(sld_crc_pkg::REQ_BYTE, 8'hFF, 1'b0);
        push_item(sld_crc_pkg::REQ_BYTE, 8'h55, 1'b0);
        push_item(sld_crc_pkg::REQ_CLEAR, 8'hFF, 1'b1);
        push_item(sld_crc_pkg::REQ_CLEAR, sld_crc_pkg::FRAME_SYNC, 1'b1);
        queue_packet(8'hFF, 16'd0, 1'b0, -1, 1'b0, 1'b0);
        queue_packet(8'h00, 16'd1, 1'b1, 8'hAA, 1'b0, 1'b0);
        queue_packet(8'hAA, 16'd2, 1'b0, 8'hFF, 1'b0, 1'b1);
        queue_packet(8'h5A, 16'd3, 1'b0, 8'h00, 1'b0, 1'b0);
        wait_idle();

        // full-size payload completes; one byte longer overflows
        queue_packet(8'($urandom_range(255)), 16'(sld_crc_pkg::MAX_PAYLOAD),
                     1'b0, -1, 1'b0, 1'b0);
        queue_packet(8'($urandom_range(255)), 16'(sld_crc_pkg::MAX_PAYLOAD + 1),
                     1'b0, -1, 1'b0, 1'b0);
        random_traffic(650);
        wait_idle();

        calm = 1'b1;
        random_traffic(900);
        wait_idle();
        calm = 1'b0;

        random_traffic(1250);
        wait_idle();
        repeat (8) @(posedge clk);

        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
